@@ rtl/lzhw_pkg.sv @@
// Shared types and constants for the LZ77 history writer.
package lzhw_pkg;

    localparam int HISTORY_DEPTH_DEF = 65536;

    localparam int LIT_W    = 8;
    localparam int LEN_W    = 16;
    localparam int DIST_W   = 16;
    localparam int ADDR_W   = 16;
    localparam int BYTES_W  = 17;

    typedef enum logic [1:0] {
        REQ_LITERAL = 2'd0,
        REQ_MATCH   = 2'd1,
        REQ_READ    = 2'd2,
        REQ_RESTART = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_BAD_DIST = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        FSM_IDLE = 4'b0001,
        FSM_READ = 4'b0010,
        FSM_COPY = 4'b0100,
        FSM_RESP = 4'b1000
    } fsm_t;

    typedef struct packed {
        status_t               status;
        logic [LIT_W-1:0]      data;
        logic [BYTES_W-1:0]    bytes;
    } result_t;

endpackage

@@ rtl/lz77_history_writer_top.sv @@
// Top level of the LZ77 history writer: sequencer, history RAM and output register.
//
// Usage:
//   Requests arrive on the s_ stream, one beat per request; s_tuser carries the
//   request kind (literal, match copy, read stored byte, restart stream).
//   Every request gives exactly one result beat on the m_ stream: the status in
//   m_tuser, the read byte and the write position after the request in m_tdata.
//   One request is worked on at a time; the next one is taken once the result
//   has moved to the output register, so requests are never overlapped.
//   A match copies one byte per cycle through the history RAM, reading the
//   source and writing the destination in the same cycle, with the just-written
//   byte forwarded when the distance is one.
//   Reset and restart set the write position to zero; entries at or above the
//   write position read as zero, so the RAM needs no clearing pass.
//   When m_tready is low the result beat holds in the output register; one
//   further request may complete behind it and then waits until it drains.
module lz77_history_writer_top
    import lzhw_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // literal_byte[7:0], match_length[23:8],
                                   // match_distance[39:24], read_address[55:40]
    input  logic [1:0]  s_tuser,   // req_type[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // read_data[7:0], bytes_written[24:8], zero[31:25]
    output logic [1:0]  m_tuser    // status[1:0]
);

    localparam int AW = $clog2(HISTORY_DEPTH);

    logic             res_valid;
    logic             res_ready;
    result_t          res;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [LIT_W-1:0] ram_wdata;
    logic             ram_re;
    logic [AW-1:0]    ram_raddr;
    logic [LIT_W-1:0] ram_rdata;

    logic    m_tvalid_reg, m_tvalid_next;
    result_t m_res_reg, m_res_next;

    lzhw_ctrl #(
        .HISTORY_DEPTH(HISTORY_DEPTH)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .req_type      (req_t'(s_tuser)),
        .literal_byte  (s_tdata[7:0]),
        .match_length  (s_tdata[23:8]),
        .match_distance(s_tdata[39:24]),
        .read_address  (s_tdata[55:40]),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res           (res),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_wdata     (ram_wdata),
        .ram_re        (ram_re),
        .ram_raddr     (ram_raddr),
        .ram_rdata     (ram_rdata)
    );

    lzhw_ram #(
        .WIDTH(LIT_W),
        .DEPTH(HISTORY_DEPTH)
    ) u_history (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_res_next    = m_res_reg;
        if (res_ready)
        begin
            m_tvalid_next = res_valid;
            if (res_valid)
            begin
                m_res_next = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_res_reg <= m_res_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_res_reg.status;
    assign m_tdata  = {7'd0, m_res_reg.bytes, m_res_reg.data};

endmodule

@@ rtl/lzhw_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
module lzhw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/lzhw_ctrl.sv @@
// Request sequencer: checks, history write position, match copy and reads.
module lzhw_ctrl
    import lzhw_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  req_t                             req_type,
    input  logic [LIT_W-1:0]                 literal_byte,
    input  logic [LEN_W-1:0]                 match_length,
    input  logic [DIST_W-1:0]                match_distance,
    input  logic [ADDR_W-1:0]                read_address,
    output logic                             res_valid,
    input  logic                             res_ready,
    output result_t                          res,
    output logic                             ram_we,
    output logic [$clog2(HISTORY_DEPTH)-1:0] ram_waddr,
    output logic [LIT_W-1:0]                 ram_wdata,
    output logic                             ram_re,
    output logic [$clog2(HISTORY_DEPTH)-1:0] ram_raddr,
    input  logic [LIT_W-1:0]                 ram_rdata
);

    localparam int AW  = $clog2(HISTORY_DEPTH);
    localparam int WPW = AW + 1;
    localparam int CW  = (WPW > ADDR_W) ? WPW : ADDR_W;
    localparam int SW  = ((WPW > BYTES_W) ? WPW : BYTES_W) + 1;

    fsm_t             state_reg, state_next;
    logic [WPW-1:0]   wp_reg, wp_next;
    logic [AW-1:0]    src_reg, src_next;
    logic [LEN_W-1:0] iss_cnt_reg, iss_cnt_next;
    logic [LEN_W-1:0] wr_cnt_reg, wr_cnt_next;
    logic             rd_pend_reg, rd_pend_next;
    logic             fwd_reg, fwd_next;
    logic [LIT_W-1:0] fwd_data_reg, fwd_data_next;
    logic             rd_ok_reg, rd_ok_next;
    status_t          status_reg, status_next;
    logic [LIT_W-1:0] data_reg, data_next;

    logic [CW-1:0]    wp_ext;
    logic [CW-1:0]    addr_ext;
    logic [CW-1:0]    dist_ext;
    logic [SW-1:0]    end_pos;
    logic [LIT_W-1:0] copy_byte;

    assign wp_ext    = CW'(wp_reg);
    assign addr_ext  = CW'(read_address);
    assign dist_ext  = CW'(match_distance);
    assign end_pos   = SW'(wp_reg) + SW'(match_length);
    assign copy_byte = fwd_reg ? fwd_data_reg : ram_rdata;

    always_comb
    begin
        state_next    = state_reg;
        wp_next       = wp_reg;
        src_next      = src_reg;
        iss_cnt_next  = iss_cnt_reg;
        wr_cnt_next   = wr_cnt_reg;
        rd_pend_next  = 1'b0;
        fwd_next      = 1'b0;
        fwd_data_next = fwd_data_reg;
        rd_ok_next    = rd_ok_reg;
        status_next   = status_reg;
        data_next     = data_reg;
        in_ready      = 1'b0;
        res_valid     = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = AW'(wp_reg);
        ram_wdata     = literal_byte;
        ram_re        = 1'b0;
        ram_raddr     = src_reg;

        unique case (state_reg)
            FSM_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    status_next = ST_OK;
                    data_next   = '0;
                    state_next  = FSM_RESP;
                    unique case (req_type)
                        REQ_LITERAL:
                        begin
                            if (wp_reg == WPW'(HISTORY_DEPTH))
                            begin
                                status_next = ST_OVERFLOW;
                            end
                            else
                            begin
                                ram_we  = 1'b1;
                                wp_next = wp_reg + WPW'(1);
                            end
                        end
                        REQ_MATCH:
                        begin
                            priority if (end_pos > SW'(HISTORY_DEPTH))
                            begin
                                status_next = ST_OVERFLOW;
                            end
                            else if (match_distance == '0 || dist_ext > wp_ext)
                            begin
                                status_next = ST_BAD_DIST;
                            end
                            else if (match_length != '0)
                            begin
                                src_next     = AW'(wp_ext - dist_ext);
                                iss_cnt_next = match_length;
                                wr_cnt_next  = match_length;
                                state_next   = FSM_COPY;
                            end
                        end
                        REQ_READ:
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = AW'(addr_ext);
                            rd_ok_next = addr_ext < wp_ext;
                            state_next = FSM_READ;
                        end
                        REQ_RESTART:
                        begin
                            wp_next = '0;
                        end
                        default:
                        begin
                            state_next = FSM_RESP;
                        end
                    endcase
                end
            end
            FSM_READ:
            begin
                data_next  = rd_ok_reg ? ram_rdata : '0;
                state_next = FSM_RESP;
            end
            FSM_COPY:
            begin
                if (iss_cnt_reg != '0)
                begin
                    ram_re       = 1'b1;
                    src_next     = src_reg + AW'(1);
                    iss_cnt_next = iss_cnt_reg - LEN_W'(1);
                    rd_pend_next = 1'b1;
                end
                if (rd_pend_reg)
                begin
                    ram_we      = 1'b1;
                    ram_wdata   = copy_byte;
                    wp_next     = wp_reg + WPW'(1);
                    wr_cnt_next = wr_cnt_reg - LEN_W'(1);
                    if (wr_cnt_reg == LEN_W'(1))
                    begin
                        state_next = FSM_RESP;
                    end
                end
                fwd_next      = ram_re && ram_we && (src_reg == AW'(wp_reg));
                fwd_data_next = copy_byte;
            end
            FSM_RESP:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    assign res.status = status_reg;
    assign res.data   = data_reg;
    assign res.bytes  = BYTES_W'(wp_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= FSM_IDLE;
            wp_reg      <= '0;
            rd_pend_reg <= 1'b0;
            fwd_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            wp_reg      <= wp_next;
            rd_pend_reg <= rd_pend_next;
            fwd_reg     <= fwd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg      <= src_next;
        iss_cnt_reg  <= iss_cnt_next;
        wr_cnt_reg   <= wr_cnt_next;
        fwd_data_reg <= fwd_data_next;
        rd_ok_reg    <= rd_ok_next;
        status_reg   <= status_next;
        data_reg     <= data_next;
    end

endmodule
